/* hdl/nplm_pkg.sv */
// Package for the nearest-peak label map: sizes, codes, the command record
// passed from the front end to the back end, and shared coordinate helpers.
// Used by the front end, the back end and the top level; depends on nothing.
package nplm_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int MAX_PEAKS  = 256;
  localparam int RADIUS     = 10;

  localparam int MAP_DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int MAP_ADDR_W = $clog2(MAP_DEPTH);
  localparam int IDX_W      = $clog2(MAX_PEAKS);
  localparam int CNT_W      = $clog2(MAX_PEAKS + 1);
  localparam int ENT_W      = IDX_W + 1;

  localparam int COORD_W    = 11;
  localparam int POS_W      = COORD_W + 1;
  localparam int QD_W       = POS_W + 1;
  localparam int PEAK_W     = 2 * COORD_W;
  localparam int CFG_W      = 9;
  localparam int OUT_IDX_W  = 8;

  localparam int DIST_W     = $clog2(RADIUS + 1);
  localparam int OFS_W      = DIST_W + 1;

  localparam int DATA_W     = 32;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_SEL_LSB = 2;

  localparam logic [CFG_W-1:0] DIM_RESET = CFG_W'(256);

  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  localparam logic REQ_ADD   = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  localparam logic signed [OFS_W-1:0] OFS_R1  = OFS_W'(RADIUS - 1);
  localparam logic signed [OFS_W-1:0] OFS_ONE = OFS_W'(1);
  localparam logic [DIST_W-1:0]       DIST_R1 = DIST_W'(RADIUS - 1);

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_QUERY = 2'd1,
    CMD_FULL  = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                  kind;
    logic                       in_image;
    logic signed [COORD_W-1:0]  x;
    logic signed [COORD_W-1:0]  y;
    logic [IDX_W-1:0]           idx;
  } cmd_t;

  typedef struct packed {
    logic pop;
    logic clearing;
  } back_stat_t;

  function automatic logic [CFG_W-1:0] eff_dim(input logic [CFG_W-1:0] raw, input int lim);
    logic [CFG_W-1:0] r;
    r = (32'(raw) > lim) ? CFG_W'(lim) : raw;
    return r;
  endfunction

  function automatic logic pos_inside(input logic signed [POS_W-1:0] x,
                                      input logic signed [POS_W-1:0] y,
                                      input logic [CFG_W-1:0] w,
                                      input logic [CFG_W-1:0] h);
    logic ok;
    ok = !x[POS_W-1] && !y[POS_W-1] &&
         ($unsigned(x) < POS_W'(w)) && ($unsigned(y) < POS_W'(h));
    return ok;
  endfunction

  function automatic logic [MAP_ADDR_W-1:0] map_addr(input logic signed [POS_W-1:0] x,
                                                      input logic signed [POS_W-1:0] y);
    logic [MAP_ADDR_W-1:0] a;
    a = MAP_ADDR_W'($unsigned(y)) * MAP_ADDR_W'(MAX_WIDTH) + MAP_ADDR_W'($unsigned(x));
    return a;
  endfunction

  function automatic logic [DIST_W-1:0] ofs_mag(input logic signed [OFS_W-1:0] v);
    logic signed [OFS_W-1:0] m;
    m = v[OFS_W-1] ? -v : v;
    return m[DIST_W-1:0];
  endfunction

  function automatic logic [POS_W-1:0] pos_absdiff(input logic signed [POS_W-1:0] a,
                                                   input logic signed [POS_W-1:0] b);
    logic signed [POS_W:0] d;
    logic signed [POS_W:0] m;
    d = (POS_W+1)'(a) - (POS_W+1)'(b);
    m = d[POS_W] ? -d : d;
    return m[POS_W-1:0];
  endfunction

endpackage

/* hdl/nplm_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Used for the label map and the peak coordinate store; no dependencies.
module nplm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/nplm_front.sv */
// Front end: accepts requests, classifies them, hands out peak indexes and
// queues commands for the back end. Depends on nplm_pkg.
module nplm_front import nplm_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  output logic                       req_ready,
  input  logic                       req_type,
  input  logic signed [COORD_W-1:0]  pos_x,
  input  logic signed [COORD_W-1:0]  pos_y,
  input  logic [CFG_W-1:0]           eff_width,
  input  logic [CFG_W-1:0]           eff_height,
  input  back_stat_t                 back_stat,
  output logic                       cmd_valid,
  output cmd_t                       cmd
);

  localparam int Q_DEPTH = 2;
  localparam int QPTR_W  = $clog2(Q_DEPTH);
  localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

  cmd_t              q_mem [Q_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] q_cnt;
  logic [CNT_W-1:0]  n_peaks;
  logic              push;
  logic              pop;
  cmd_t              new_cmd;

  assign req_ready = (q_cnt != QCNT_W'(Q_DEPTH)) && !back_stat.clearing;
  assign push      = req_valid && req_ready;
  assign pop       = back_stat.pop && cmd_valid;
  assign cmd_valid = (q_cnt != '0);
  assign cmd       = q_mem[rd_ptr];

  always_comb begin
    new_cmd.x        = pos_x;
    new_cmd.y        = pos_y;
    new_cmd.idx      = n_peaks[IDX_W-1:0];
    new_cmd.in_image = pos_inside(POS_W'(pos_x), POS_W'(pos_y), eff_width, eff_height);
    if (req_type == REQ_QUERY) begin
      new_cmd.kind = CMD_QUERY;
    end else if (n_peaks == CNT_W'(MAX_PEAKS)) begin
      new_cmd.kind = CMD_FULL;
    end else begin
      new_cmd.kind = CMD_ADD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      q_cnt   <= '0;
      n_peaks <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
        if (new_cmd.kind == CMD_ADD) begin
          n_peaks <= n_peaks + CNT_W'(1);
        end
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      q_cnt <= q_cnt + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= new_cmd;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    n_peaks <= CNT_W'(MAX_PEAKS))
    else $error("peak count beyond store size");

  a_queue_empty_clear: assert property (@(posedge clk) disable iff (rst)
    back_stat.clearing |-> (q_cnt == '0))
    else $error("command queued during clearing pass");

  a_count_advance: assert property (@(posedge clk) disable iff (rst)
    (push && new_cmd.kind == CMD_ADD) |=> (n_peaks == $past(n_peaks) + CNT_W'(1)))
    else $error("peak count did not advance on add");

endmodule

/* hdl/nplm_back.sv */
// Back end: clears the label map after reset, runs queries, stores peaks and
// sweeps their diamond through a read-compare-write pipeline; owns the result
// register. Depends on nplm_pkg and nplm_ram.
module nplm_back import nplm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_valid,
  input  cmd_t                  cmd,
  output back_stat_t            back_stat,
  input  logic [CFG_W-1:0]      eff_width,
  input  logic [CFG_W-1:0]      eff_height,
  output logic                  rsp_valid,
  input  logic                  rsp_ready,
  output logic                  found,
  output logic [OUT_IDX_W-1:0]  label_id,
  output logic                  status
);

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_QWAIT = 6'b000100,
    ST_SWEEP = 6'b001000,
    ST_DRAIN = 6'b010000,
    ST_RESP  = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  logic [MAP_ADDR_W-1:0]      clr_cnt;
  logic                       pop;

  logic signed [COORD_W-1:0]  cur_x;
  logic signed [COORD_W-1:0]  cur_y;
  logic [IDX_W-1:0]           cur_idx;
  logic signed [OFS_W-1:0]    dx;
  logic signed [OFS_W-1:0]    dy;

  logic                       res_found;
  logic [OUT_IDX_W-1:0]       res_idx;
  logic                       res_status;

  logic [DIST_W-1:0]          span;
  logic [DIST_W-1:0]          span_inc;
  logic signed [OFS_W-1:0]    dx_inc;
  logic                       last_dy;
  logic                       last_pt;
  logic signed [POS_W-1:0]    pt_x;
  logic signed [POS_W-1:0]    pt_y;
  logic [DIST_W-1:0]          pt_dist;

  logic                       s1_v, s2_v, s3_v;
  logic                       s1_live, s2_live, s3_live;
  logic [MAP_ADDR_W-1:0]      s1_addr, s2_addr, s3_addr;
  logic signed [POS_W-1:0]    s1_x, s1_y, s2_x, s2_y;
  logic [DIST_W-1:0]          s1_dist, s2_dist, s3_dist;
  logic                       s2_lab_v, s3_lab_v;
  logic [QD_W-1:0]            s3_qdist;
  logic [QD_W-1:0]            qdist;

  logic                       lbl_we;
  logic [MAP_ADDR_W-1:0]      lbl_waddr;
  logic [ENT_W-1:0]           lbl_wdata;
  logic [MAP_ADDR_W-1:0]      lbl_raddr;
  logic [ENT_W-1:0]           lbl_rdata;
  logic                       peak_we;
  logic [PEAK_W-1:0]          peak_rdata;
  logic                       rsp_load;
  logic                       s3_upd;

  nplm_ram #(.WIDTH(ENT_W), .DEPTH(MAP_DEPTH)) u_label_ram (
    .clk   (clk),
    .we    (lbl_we),
    .waddr (lbl_waddr),
    .wdata (lbl_wdata),
    .raddr (lbl_raddr),
    .rdata (lbl_rdata)
  );

  nplm_ram #(.WIDTH(PEAK_W), .DEPTH(MAX_PEAKS)) u_peak_ram (
    .clk   (clk),
    .we    (peak_we),
    .waddr (cmd.idx),
    .wdata ({cmd.x, cmd.y}),
    .raddr (lbl_rdata[IDX_W-1:0]),
    .rdata (peak_rdata)
  );

  assign back_stat.pop      = pop;
  assign back_stat.clearing = (state == ST_CLEAR);

  always_comb begin
    span     = DIST_R1 - ofs_mag(dx);
    dx_inc   = dx + OFS_ONE;
    span_inc = DIST_R1 - ofs_mag(dx_inc);
    last_dy  = (dy == signed'({1'b0, span}));
    last_pt  = last_dy && (dx == OFS_R1);
    pt_x     = POS_W'(cur_x) + POS_W'(dx);
    pt_y     = POS_W'(cur_y) + POS_W'(dy);
    pt_dist  = ofs_mag(dx) + ofs_mag(dy);
    qdist    = QD_W'(pos_absdiff(POS_W'($signed(peak_rdata[PEAK_W-1:COORD_W])), s2_x)) +
               QD_W'(pos_absdiff(POS_W'($signed(peak_rdata[COORD_W-1:0])), s2_y));
    s3_upd   = s3_v && s3_live && (!s3_lab_v || (QD_W'(s3_dist) < s3_qdist));
    rsp_load = (state == ST_RESP) && (!rsp_valid || rsp_ready);
  end

  always_comb begin
    if (state == ST_CLEAR) begin
      lbl_we    = 1'b1;
      lbl_waddr = clr_cnt;
      lbl_wdata = '0;
    end else begin
      lbl_we    = s3_upd;
      lbl_waddr = s3_addr;
      lbl_wdata = {1'b1, cur_idx};
    end
    if (state == ST_SWEEP) begin
      lbl_raddr = map_addr(pt_x, pt_y);
    end else begin
      lbl_raddr = map_addr(POS_W'(cmd.x), POS_W'(cmd.y));
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    peak_we    = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        if (clr_cnt == MAP_ADDR_W'(MAP_DEPTH - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (cmd_valid) begin
          pop = 1'b1;
          unique case (cmd.kind)
            CMD_ADD: begin
              peak_we    = 1'b1;
              state_next = ST_SWEEP;
            end
            CMD_QUERY: state_next = cmd.in_image ? ST_QWAIT : ST_RESP;
            default:   state_next = ST_RESP;
          endcase
        end
      end
      ST_QWAIT: state_next = ST_RESP;
      ST_SWEEP: begin
        if (last_pt) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!s1_v && !s2_v && !s3_v) state_next = ST_RESP;
      end
      ST_RESP: begin
        if (rsp_load) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      s1_v      <= 1'b0;
      s2_v      <= 1'b0;
      s3_v      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + MAP_ADDR_W'(1);
      end
      s1_v <= (state == ST_SWEEP);
      s2_v <= s1_v;
      s3_v <= s2_v;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_x   <= cmd.x;
      cur_y   <= cmd.y;
      cur_idx <= cmd.idx;
      dx      <= -OFS_R1;
      dy      <= '0;
      unique case (cmd.kind)
        CMD_ADD: begin
          res_found  <= 1'b1;
          res_idx    <= OUT_IDX_W'(cmd.idx);
          res_status <= STATUS_OK;
        end
        CMD_FULL: begin
          res_found  <= 1'b0;
          res_idx    <= '0;
          res_status <= STATUS_FULL;
        end
        default: begin
          res_found  <= 1'b0;
          res_idx    <= '0;
          res_status <= STATUS_OK;
        end
      endcase
    end
    if (state == ST_QWAIT) begin
      res_found <= lbl_rdata[ENT_W-1];
      res_idx   <= lbl_rdata[ENT_W-1] ? OUT_IDX_W'(lbl_rdata[IDX_W-1:0]) : '0;
    end
    if (state == ST_SWEEP) begin
      if (last_dy) begin
        dx <= dx_inc;
        dy <= -signed'({1'b0, span_inc});
      end else begin
        dy <= dy + OFS_ONE;
      end
    end

    s1_live  <= pos_inside(pt_x, pt_y, eff_width, eff_height);
    s1_addr  <= map_addr(pt_x, pt_y);
    s1_x     <= pt_x;
    s1_y     <= pt_y;
    s1_dist  <= pt_dist;

    s2_live  <= s1_live;
    s2_addr  <= s1_addr;
    s2_x     <= s1_x;
    s2_y     <= s1_y;
    s2_dist  <= s1_dist;
    s2_lab_v <= lbl_rdata[ENT_W-1];

    s3_live  <= s2_live;
    s3_addr  <= s2_addr;
    s3_dist  <= s2_dist;
    s3_lab_v <= s2_lab_v;
    s3_qdist <= qdist;

    if (rsp_load) begin
      found    <= res_found;
      label_id <= res_idx;
      status   <= res_status;
    end
  end

  a_pipe_in_sweep: assert property (@(posedge clk) disable iff (rst)
    (s1_v || s2_v || s3_v) |-> (state == ST_SWEEP || state == ST_DRAIN))
    else $error("sweep pipeline active outside an add");

  a_label_write_src: assert property (@(posedge clk) disable iff (rst)
    lbl_we |-> (state == ST_CLEAR || (s3_v && s3_live)))
    else $error("label map written without a live sweep point");

  a_drain_empty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RESP) |-> (!s1_v && !s2_v && !s3_v))
    else $error("result issued before sweep drained");

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    pop |=> (state != ST_IDLE && state != ST_CLEAR))
    else $error("popped command not taken up");

endmodule

/* hdl/nearest_peak_label_map_top.sv */
// Top level of the nearest-peak label map: configuration registers on an
// APB-style port, front end, back end. Depends on nplm_pkg, nplm_front, nplm_back.
//
//   channel  | signals                                    | role
//   ---------+--------------------------------------------+--------------------------
//   request  | req_valid/req_ready, req_type, pos_x, pos_y | add or query, one per txn
//   response | rsp_valid/rsp_ready, found, label_id,      | one result per request
//            | status                                     |
//   config   | psel, penable, pwrite, paddr, pwdata,      | image_width @0,
//            | prdata, pready                             | image_height @4
//
// A query inside the image reads the label map in ST_QWAIT before its response;
// an add with the store full answers without a sweep; any other add sweeps the
// 181 diamond points, one label-map read and at most one write per point.
// After reset a clearing pass writes all 65536 label-map entries, one per
// cycle; req_ready stays low until it ends, config writes are still taken.
// A two-entry command queue lets requests be accepted while the back end
// works or a response waits; the response register holds until taken.
module nearest_peak_label_map_top import nplm_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  output logic                       req_ready,
  input  logic                       req_type,
  input  logic signed [COORD_W-1:0]  pos_x,
  input  logic signed [COORD_W-1:0]  pos_y,
  output logic                       rsp_valid,
  input  logic                       rsp_ready,
  output logic                       found,
  output logic [OUT_IDX_W-1:0]       label_id,
  output logic                       status,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [CFG_ADDR_W-1:0]      paddr,
  input  logic [DATA_W-1:0]          pwdata,
  output logic [DATA_W-1:0]          prdata,
  output logic                       pready
);

  logic [CFG_W-1:0] image_width;
  logic [CFG_W-1:0] image_height;
  logic [CFG_W-1:0] eff_width;
  logic [CFG_W-1:0] eff_height;
  logic             reg_sel;
  logic             cfg_wr;
  logic             cmd_valid;
  cmd_t             cmd;
  back_stat_t       back_stat;

  assign pready     = 1'b1;
  assign reg_sel    = paddr[CFG_SEL_LSB];
  assign cfg_wr     = psel && penable && pwrite && pready;
  assign eff_width  = eff_dim(image_width, MAX_WIDTH);
  assign eff_height = eff_dim(image_height, MAX_HEIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= DIM_RESET;
      image_height <= DIM_RESET;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_IMAGE_WIDTH:  image_width  <= pwdata[CFG_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= pwdata[CFG_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_IMAGE_WIDTH:  prdata = DATA_W'(image_width);
      REG_IMAGE_HEIGHT: prdata = DATA_W'(image_height);
    endcase
  end

  nplm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req_type   (req_type),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .eff_width  (eff_width),
    .eff_height (eff_height),
    .back_stat  (back_stat),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd)
  );

  nplm_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .back_stat  (back_stat),
    .eff_width  (eff_width),
    .eff_height (eff_height),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .found      (found),
    .label_id   (label_id),
    .status     (status)
  );

endmodule
